@@ hdl/dci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_pkg
// Shared types and action codes of the drive command interpreter.
// ----------------------------------------------------------------------------
package dci_pkg;

	localparam logic [2:0] KIND_LAMP1  = 3'd0;
	localparam logic [2:0] KIND_LAMP2  = 3'd1;
	localparam logic [2:0] KIND_MOTOR  = 3'd2;
	localparam logic [2:0] KIND_SERVO  = 3'd3;
	localparam logic [2:0] KIND_SENSOR = 3'd4;

	localparam logic [6:0] PCT_MAX = 7'd100;

	typedef struct packed {
		logic       right_forward;
		logic [6:0] right_duty;
		logic       left_forward;
		logic [6:0] left_duty;
	} motor_t;

	typedef struct packed {
		logic [2:0] action_kind;
		logic [2:0] lamp_colour;
		motor_t     motor;
		logic [7:0] top_servo_percent;
		logic [7:0] bottom_servo_percent;
	} result_t;

endpackage

@@ hdl/dci_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_if
// Valid/ready channels: received command bytes and interpreted actions.
// ----------------------------------------------------------------------------
interface dci_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dci_action_if;
	logic       valid;
	logic       ready;
	logic [2:0] action_kind;
	logic [2:0] lamp_colour;
	logic       right_forward;
	logic [6:0] right_duty;
	logic       left_forward;
	logic [6:0] left_duty;
	logic [7:0] top_servo_percent;
	logic [7:0] bottom_servo_percent;

	modport source (
		output valid, output action_kind, output lamp_colour,
		output right_forward, output right_duty, output left_forward, output left_duty,
		output top_servo_percent, output bottom_servo_percent, input ready
	);
	modport sink (
		input valid, input action_kind, input lamp_colour,
		input right_forward, input right_duty, input left_forward, input left_duty,
		input top_servo_percent, input bottom_servo_percent, output ready
	);
endinterface

@@ hdl/dci_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_mixer
// Joystick to differential drive mixing of clamped X and Y percentages.
// ----------------------------------------------------------------------------
module dci_mixer (
	input  logic [6:0]      x_pct,
	input  logic [6:0]      y_pct,
	output dci_pkg::motor_t motor
);
	import dci_pkg::*;

	logic [5:0] dx, dy;
	logic [9:0] px, py;
	logic [3:0] qx, qy, qm;
	logic       xneg, yneg, xge0, xle0, yge0, yle0;
	logic [6:0] mm, ty, r3, r1;
	logic [8:0] three;
	logic       r_neg, l_neg;
	logic [6:0] r_mag, l_mag;

	always_comb begin
		// axis magnitude in tens: |v-50|/5
		dx = (x_pct >= 7'd50) ? 6'(x_pct - 7'd50) : 6'(7'd50 - x_pct);
		dy = (y_pct >= 7'd50) ? 6'(y_pct - 7'd50) : 6'(7'd50 - y_pct);
		px = {4'd0, dx} * 10'd13;
		py = {4'd0, dy} * 10'd13;
		qx = px[9:6];
		qy = py[9:6];
		xneg = (x_pct < 7'd50) && (qx != 4'd0);
		yneg = (y_pct < 7'd50) && (qy != 4'd0);
		xge0 = !xneg;
		xle0 = xneg || (qx == 4'd0);
		yge0 = !yneg;
		yle0 = yneg || (qy == 4'd0);
		qm = (qx > qy) ? qx : qy;
		mm = 7'({3'd0, qm} * 7'd10);
		ty = 7'({3'd0, qy} * 7'd10);
		three = {1'b0, mm, 1'b0} + {2'b00, mm};
		r3 = three[8:2];
		r1 = {2'b00, mm[6:2]};

		priority if (x_pct == 7'd0 && y_pct == 7'd0) begin
			r_neg = 1'b0; r_mag = 7'd0; l_neg = 1'b0; l_mag = 7'd0;
		end else if (qx <= 4'd2 && qy == 4'd10 && !yneg) begin
			r_neg = 1'b0; r_mag = PCT_MAX; l_neg = 1'b0; l_mag = PCT_MAX;
		end else if (qx <= 4'd2 && qy == 4'd10 && yneg) begin
			r_neg = 1'b1; r_mag = PCT_MAX; l_neg = 1'b1; l_mag = PCT_MAX;
		end else if (qx == 4'd0) begin
			r_neg = yneg; r_mag = ty; l_neg = yneg; l_mag = ty;
		end else if (qx == 4'd10 && !xneg && qy <= 4'd2) begin
			r_neg = 1'b0; r_mag = 7'd50; l_neg = 1'b1; l_mag = 7'd50;
		end else if (qx == 4'd10 && xneg && qy <= 4'd2) begin
			r_neg = 1'b1; r_mag = 7'd50; l_neg = 1'b0; l_mag = 7'd50;
		end else if (xge0 && yge0) begin
			r_neg = 1'b0; r_mag = r3; l_neg = 1'b0; l_mag = r1;
		end else if (xle0 && yge0) begin
			r_neg = 1'b0; r_mag = r1; l_neg = 1'b0; l_mag = r3;
		end else if (xle0 && yle0) begin
			r_neg = 1'b1; r_mag = r3; l_neg = 1'b1; l_mag = r1;
		end else begin
			r_neg = 1'b1; r_mag = r1; l_neg = 1'b1; l_mag = r3;
		end

		// zero duty reads as forward
		motor.right_forward = !(r_neg && r_mag != 7'd0);
		motor.right_duty    = r_mag;
		motor.left_forward  = !(l_neg && l_mag != 7'd0);
		motor.left_duty     = l_mag;
	end

endmodule

@@ hdl/dci_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_parser
// Command byte parser: phase register, first argument and result forming.
// ----------------------------------------------------------------------------
module dci_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output logic             res_valid,
	output dci_pkg::result_t res
);
	import dci_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_LAMP1 = 3'd1;
	localparam logic [2:0] PH_LAMP2 = 3'd2;
	localparam logic [2:0] PH_MOT_X = 3'd3;
	localparam logic [2:0] PH_MOT_Y = 3'd4;
	localparam logic [2:0] PH_SRV_X = 3'd5;
	localparam logic [2:0] PH_SRV_Y = 3'd6;

	localparam logic [7:0] CMD_LAMP1  = 8'd11;
	localparam logic [7:0] CMD_LAMP2  = 8'd12;
	localparam logic [7:0] CMD_MOTOR  = 8'd21;
	localparam logic [7:0] CMD_SERVO  = 8'd22;
	localparam logic [7:0] CMD_SENSOR = 8'd51;

	logic [2:0]  phase_q, phase_d;
	logic [6:0]  first_q, first_d;
	logic [6:0]  arg;
	motor_t      mix;
	logic [9:0]  nt, nb;
	logic [17:0] pt, pb;
	logic [7:0]  top_pct, bot_pct;

	assign arg = (rx_byte > {1'b0, PCT_MAX}) ? PCT_MAX : rx_byte[6:0];

	dci_mixer u_mixer (
		.x_pct (first_q),
		.y_pct (arg),
		.motor (mix)
	);

	always_comb begin
		// divide by 5 and by 10 through reciprocal 205/1024
		nt = {first_q, 3'b000};
		nb = 10'({3'd0, arg} * 10'd9);
		pt = {8'd0, nt} * 18'd205;
		pb = {8'd0, nb} * 18'd205;
		top_pct = pt[17:10] + 8'd10;
		bot_pct = {1'b0, pb[17:11]} + 8'd45;
	end

	always_comb begin
		phase_d   = PH_IDLE;
		first_d   = first_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_LAMP1, PH_LAMP2: begin
				res_valid       = 1'b1;
				res.action_kind = (phase_q == PH_LAMP1) ? KIND_LAMP1 : KIND_LAMP2;
				res.lamp_colour = rx_byte[2:0];
			end
			PH_MOT_X: begin
				first_d = arg;
				phase_d = PH_MOT_Y;
			end
			PH_MOT_Y: begin
				res_valid       = 1'b1;
				res.action_kind = KIND_MOTOR;
				res.motor       = mix;
			end
			PH_SRV_X: begin
				first_d = arg;
				phase_d = PH_SRV_Y;
			end
			PH_SRV_Y: begin
				res_valid                = 1'b1;
				res.action_kind          = KIND_SERVO;
				res.top_servo_percent    = top_pct;
				res.bottom_servo_percent = bot_pct;
			end
			default: begin
				priority if (rx_byte == CMD_LAMP1) begin
					phase_d = PH_LAMP1;
				end else if (rx_byte == CMD_LAMP2) begin
					phase_d = PH_LAMP2;
				end else if (rx_byte == CMD_MOTOR) begin
					phase_d = PH_MOT_X;
				end else if (rx_byte == CMD_SERVO) begin
					phase_d = PH_SRV_X;
				end else if (rx_byte == CMD_SENSOR) begin
					res_valid       = 1'b1;
					res.action_kind = KIND_SENSOR;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= 7'd0;
		end else if (step) begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

`ifndef ASSERT_OFF
	a_first_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		first_q <= PCT_MAX)
		else $error("first argument above clamp");
	a_y_follows_x: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_MOT_X || phase_q == PH_SRV_X) |=> !res_valid || !$past(step)
		|| phase_q == PH_MOT_Y || phase_q == PH_SRV_Y)
		else $error("second argument phase lost");
	a_arg_phase_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MOT_X || phase_q == PH_SRV_X) |-> !res_valid)
		else $error("result on first argument");
`endif

endmodule

@@ hdl/drive_command_interpreter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_interpreter_top
// Serial command interpreter for lamps, differential drive motors and servos.
// ----------------------------------------------------------------------------
// usage
//   cmd: valid/ready byte channel, one received command or argument byte
//   per transfer
//   act: valid/ready action channel, one transfer for each byte that
//   completes a command (lamp, motors, servos, sensor dump request)
//   bytes that open a multi-byte command or are unknown give no transfer on act
// throughput and pipeline
//   a completing byte is held in the input register, then its action in the action register, before it shows on act
//   one byte per cycle sustained while act is not held off; the input register and the action
//   register form a two stage pipeline
// reset
//   arst_n clears both pipeline valids and returns the parser to idle
// stall
//   while act is held off, the input register still takes one more byte;
//   cmd.ready drops once that register is full and cannot move on
// ----------------------------------------------------------------------------
module drive_command_interpreter_top (
	input logic         clk,
	input logic         arst_n,
	dci_byte_if.sink    cmd,
	dci_action_if.source act
);
	import dci_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       res_valid;
	result_t    res;
	logic       act_valid_q;
	result_t    act_q;

	assign adv       = valid_s1 && (!act_valid_q || act.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			byte_s1 <= cmd.rx_byte;
		end
	end

	dci_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			act_valid_q <= 1'b1;
		end else if (act.ready) begin
			act_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			act_q <= res;
		end
	end

	assign act.valid                = act_valid_q;
	assign act.action_kind          = act_q.action_kind;
	assign act.lamp_colour          = act_q.lamp_colour;
	assign act.right_forward        = act_q.motor.right_forward;
	assign act.right_duty           = act_q.motor.right_duty;
	assign act.left_forward         = act_q.motor.left_forward;
	assign act.left_duty            = act_q.motor.left_duty;
	assign act.top_servo_percent    = act_q.top_servo_percent;
	assign act.bottom_servo_percent = act_q.bottom_servo_percent;

`ifndef ASSERT_OFF
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && act.valid && !act.ready |-> !cmd.ready)
		else $error("input taken while both stages are blocked");
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> valid_s1)
		else $error("accepted byte lost");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		act.valid |-> act.action_kind <= KIND_SENSOR)
		else $error("action code out of range");
	a_duty_only_motor: assert property (@(posedge clk) disable iff (!arst_n)
		act.valid && act.action_kind != KIND_MOTOR |->
		act.right_duty == 7'd0 && act.left_duty == 7'd0)
		else $error("motor duty on non motor action");
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		act.valid |-> act.right_duty <= PCT_MAX && act.left_duty <= PCT_MAX)
		else $error("motor duty above full scale");
`endif

endmodule
